// ----- hw/rtl/mtg_pkg.sv -----
package mtg_pkg;

    localparam int STATE_WORDS   = 624;
    localparam int TWIST_OFFSET  = 397;
    localparam int NEVER_SEEDED  = STATE_WORDS + 1;
    localparam int FAR_WRAP      = STATE_WORDS - TWIST_OFFSET;

    localparam int ADDR_W = $clog2(STATE_WORDS);
    localparam int CNT_W  = $clog2(NEVER_SEEDED + 1);
    localparam int WORD_W = 32;

    localparam logic [1:0] CMD_GENERATE = 2'd0;
    localparam logic [1:0] CMD_SEED     = 2'd1;
    localparam logic [1:0] CMD_LOAD     = 2'd2;

    localparam logic [WORD_W-1:0] MT_MATRIX    = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd4357;
    localparam logic [WORD_W-1:0] LCG_MULT     = 32'd69069;
    localparam logic [WORD_W-1:0] LCG_INC      = 32'd1;
    localparam logic [WORD_W-1:0] LCG_MULT2    = 32'(64'd69069 * 64'd69069);
    localparam logic [WORD_W-1:0] LCG_INC2     = LCG_MULT + LCG_INC;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GEN_OUT,
        ST_SEED,
        ST_TW_PRIME,
        ST_TW_RUN
    } mtg_state_t;

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic logic [ADDR_W-1:0] next_addr(input logic [ADDR_W-1:0] k);
        logic [ADDR_W-1:0] r;
        if (k == ADDR_W'(STATE_WORDS - 1))
            r = '0;
        else
            r = k + ADDR_W'(1);
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] far_addr(input logic [ADDR_W-1:0] k);
        logic [ADDR_W-1:0] r;
        if (k < ADDR_W'(FAR_WRAP))
            r = k + ADDR_W'(TWIST_OFFSET);
        else
            r = k - ADDR_W'(FAR_WRAP);
        return r;
    endfunction

endpackage

// ----- hw/rtl/mtg_if.sv -----
interface mtg_in_if import mtg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [WORD_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface mtg_out_if import mtg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

// ----- hw/rtl/mtg_ram.sv -----
module mtg_ram #(
    parameter int DEPTH = 624,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re_a,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic             re_b,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re_a)
        begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b)
        begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ----- hw/rtl/mtg_lcg.sv -----
module mtg_lcg import mtg_pkg::*; (
    input  logic              clk,
    input  logic              load,
    input  logic              step,
    input  logic [WORD_W-1:0] seed,
    output logic [WORD_W-1:0] word
);

    logic [WORD_W-1:0] s_reg;
    logic [WORD_W-1:0] s_next;
    logic [WORD_W-1:0] s_one;
    logic [WORD_W-1:0] s_two;

    // Each table word takes two generator steps; the second is folded into one product.
    assign s_one = s_reg * LCG_MULT + LCG_INC;
    assign s_two = s_reg * LCG_MULT2 + LCG_INC2;
    assign word  = {s_reg[WORD_W-1:WORD_W/2], s_one[WORD_W-1:WORD_W/2]};

    always_comb
    begin
        s_next = s_reg;
        if (load)
            s_next = seed;
        else if (step)
            s_next = s_two;
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
    end

endmodule

// ----- hw/rtl/mtg_out.sv -----
module mtg_out import mtg_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [WORD_W-1:0] word,
    output logic              slot_free,
    mtg_out_if.source         response
);

    logic              valid_reg;
    logic              valid_next;
    logic [WORD_W-1:0] data_reg;

    assign slot_free             = !valid_reg || response.ready;
    assign response.valid        = valid_reg;
    assign response.random_value = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (response.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= temper(word);
        end
    end

endmodule

// ----- hw/rtl/mersenne_twister_generator.sv -----
// Generate: one word per cycle while unread words remain and the result slot is free.
// A generate that finds the table used up twists it first, then the word follows.
// Seed: writes all 624 table words, one table word per cycle. Load: one word per transfer.
// The state table memory has a single write port and two read ports.
// Reset clears control state; the table is unseeded and is seeded with 4357 on a generate before any seed or load.
module mersenne_twister_generator import mtg_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    mtg_in_if.sink    request,
    mtg_out_if.source response
);

    mtg_state_t        state_reg;
    mtg_state_t        state_next;
    logic [CNT_W-1:0]  read_index_reg;
    logic [CNT_W-1:0]  read_index_next;
    logic [ADDR_W-1:0] load_ptr_reg;
    logic [ADDR_W-1:0] load_ptr_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              gen_pend_reg;
    logic              gen_pend_next;
    logic [WORD_W-1:0] cur_reg;
    logic [WORD_W-1:0] cur_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              rd_a_en;
    logic [ADDR_W-1:0] rd_a_addr;
    logic [WORD_W-1:0] rd_a_data;
    logic              rd_b_en;
    logic [ADDR_W-1:0] rd_b_addr;
    logic [WORD_W-1:0] rd_b_data;

    logic              lcg_load;
    logic              lcg_step;
    logic [WORD_W-1:0] lcg_seed;
    logic [WORD_W-1:0] lcg_word;

    logic              out_load;
    logic              slot_free;
    logic              take;
    logic [WORD_W-1:0] twist_y;
    logic [WORD_W-1:0] twist_word;

    mtg_ram #(
        .DEPTH (STATE_WORDS),
        .WIDTH (WORD_W)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re_a    (rd_a_en),
        .raddr_a (rd_a_addr),
        .rdata_a (rd_a_data),
        .re_b    (rd_b_en),
        .raddr_b (rd_b_addr),
        .rdata_b (rd_b_data)
    );

    mtg_lcg u_lcg (
        .clk  (clk),
        .load (lcg_load),
        .step (lcg_step),
        .seed (lcg_seed),
        .word (lcg_word)
    );

    mtg_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .word      (rd_a_data),
        .slot_free (slot_free),
        .response  (response)
    );

    assign take          = (state_reg == ST_IDLE) || (state_reg == ST_GEN_OUT && slot_free);
    assign request.ready = take;

    // The word at k comes from the previous read of its successor; successor and far word are
    // read now, so the write of entry k-1 never meets a read address in the same cycle.
    assign twist_y    = {cur_reg[WORD_W-1], rd_a_data[WORD_W-2:0]};
    assign twist_word = rd_b_data ^ (twist_y >> 1) ^ (twist_y[0] ? MT_MATRIX : '0);

    always_comb
    begin
        state_next      = state_reg;
        read_index_next = read_index_reg;
        load_ptr_next   = load_ptr_reg;
        cnt_next        = cnt_reg;
        gen_pend_next   = gen_pend_reg;
        cur_next        = cur_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        rd_a_en         = 1'b0;
        rd_a_addr       = '0;
        rd_b_en         = 1'b0;
        rd_b_addr       = '0;
        lcg_load        = 1'b0;
        lcg_step        = 1'b0;
        lcg_seed        = request.value;
        out_load        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_GEN_OUT:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SEED:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[ADDR_W-1:0];
                ram_wdata = lcg_word;
                lcg_step  = 1'b1;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(STATE_WORDS - 1))
                begin
                    cnt_next        = '0;
                    read_index_next = CNT_W'(STATE_WORDS);
                    gen_pend_next   = 1'b0;
                    state_next      = gen_pend_reg ? ST_TW_PRIME : ST_IDLE;
                end
            end
            ST_TW_PRIME:
            begin
                rd_a_en    = 1'b1;
                rd_a_addr  = '0;
                cnt_next   = '0;
                state_next = ST_TW_RUN;
            end
            ST_TW_RUN:
            begin
                cur_next = rd_a_data;
                if (cnt_reg != '0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(cnt_reg - CNT_W'(1));
                    ram_wdata = twist_word;
                end
                if (cnt_reg != CNT_W'(STATE_WORDS))
                begin
                    rd_a_en   = 1'b1;
                    rd_a_addr = next_addr(cnt_reg[ADDR_W-1:0]);
                    rd_b_en   = 1'b1;
                    rd_b_addr = far_addr(cnt_reg[ADDR_W-1:0]);
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    rd_a_en         = 1'b1;
                    rd_a_addr       = '0;
                    read_index_next = CNT_W'(1);
                    cnt_next        = '0;
                    state_next      = ST_GEN_OUT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (take && request.valid)
        begin
            unique case (request.command)
                CMD_GENERATE:
                begin
                    if (read_index_reg == CNT_W'(NEVER_SEEDED))
                    begin
                        lcg_load      = 1'b1;
                        lcg_seed      = DEFAULT_SEED;
                        gen_pend_next = 1'b1;
                        cnt_next      = '0;
                        state_next    = ST_SEED;
                    end
                    else if (read_index_reg >= CNT_W'(STATE_WORDS))
                    begin
                        state_next = ST_TW_PRIME;
                    end
                    else
                    begin
                        rd_a_en         = 1'b1;
                        rd_a_addr       = read_index_reg[ADDR_W-1:0];
                        read_index_next = read_index_reg + CNT_W'(1);
                        state_next      = ST_GEN_OUT;
                    end
                end
                CMD_SEED:
                begin
                    lcg_load      = 1'b1;
                    lcg_seed      = request.value;
                    load_ptr_next = '0;
                    cnt_next      = '0;
                    gen_pend_next = 1'b0;
                    state_next    = ST_SEED;
                end
                CMD_LOAD:
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = load_ptr_reg;
                    ram_wdata       = request.value;
                    load_ptr_next   = (load_ptr_reg == ADDR_W'(STATE_WORDS - 1)) ? '0
                                      : load_ptr_reg + ADDR_W'(1);
                    read_index_next = CNT_W'(STATE_WORDS);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            read_index_reg <= CNT_W'(NEVER_SEEDED);
            load_ptr_reg   <= '0;
            cnt_reg        <= '0;
            gen_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            read_index_reg <= read_index_next;
            load_ptr_reg   <= load_ptr_next;
            cnt_reg        <= cnt_next;
            gen_pend_reg   <= gen_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    a_load_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        load_ptr_reg <= ADDR_W'(STATE_WORDS - 1))
        else $error("load pointer out of range");

    a_read_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        read_index_reg <= CNT_W'(NEVER_SEEDED))
        else $error("read index out of range");

    a_twist_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TW_RUN && ram_we) |->
            ((!rd_a_en || ram_waddr != rd_a_addr) && (!rd_b_en || ram_waddr != rd_b_addr)))
        else $error("twist write collides with a read");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (slot_free && state_reg == ST_GEN_OUT))
        else $error("result register overwritten");

    a_twist_ends_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TW_RUN && cnt_reg == CNT_W'(STATE_WORDS)) |=>
            (state_reg == ST_GEN_OUT && read_index_reg == CNT_W'(1)))
        else $error("twist did not hand over to the first read");

endmodule
